>>> design/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define ASP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked check that also runs through reset
`define ASP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> design/asp_pkg.sv
// types and constants of the attitude and speed controller
`timescale 1ns / 1ps

package asp_pkg;

   localparam int unsigned TURN       = 36000;
   localparam int unsigned HALF_TURN  = 18000;
   localparam int unsigned ROLL_CAP   = 18000;
   localparam int unsigned PITCH_CAP  = 9000;
   localparam int unsigned POWER_FULL = 32767;

   localparam logic [15:0] SPEED_GAIN_P_RESET  = 16'd256;
   localparam logic [15:0] SPEED_GAIN_I_RESET  = 16'd16;
   localparam logic [15:0] HEADING_GAIN_RESET  = 16'd256;
   localparam logic [15:0] ALTITUDE_GAIN_RESET = 16'd256;
   localparam logic [14:0] ROLL_LIMIT_RESET    = 15'd3000;
   localparam logic [13:0] PITCH_LIMIT_RESET   = 14'd2000;

   typedef enum logic [2:0] {
      CSR_SPEED_GAIN_P  = 3'd0,
      CSR_SPEED_GAIN_I  = 3'd1,
      CSR_HEADING_GAIN  = 3'd2,
      CSR_ALTITUDE_GAIN = 3'd3,
      CSR_ROLL_LIMIT    = 3'd4,
      CSR_PITCH_LIMIT   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] ground_speed;
      logic signed [15:0] target_speed;
      logic        [15:0] heading_now;
      logic        [15:0] target_heading;
      logic signed [17:0] altitude_now;
      logic signed [17:0] target_altitude;
   } sample_type;

   typedef struct packed {
      logic               speed_off;
      logic signed [16:0] speed_err;
      logic signed [31:0] err_sum;
      logic signed [16:0] heading_err;
      logic signed [18:0] altitude_err;
   } err_type;

   typedef struct packed {
      logic               speed_off;
      logic signed [33:0] p_term;
      logic signed [48:0] i_term;
      logic signed [33:0] roll_prod;
      logic signed [35:0] pitch_prod;
   } prod_type;

endpackage

>>> design/asp_err_stage.sv
// error stage: speed integrator with its state, heading wrap and altitude error
`timescale 1ns / 1ps

module asp_err_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                commit,
   input  asp_pkg::sample_type sample,
   output asp_pkg::err_type    err
);
   import asp_pkg::*;

   logic signed [31:0] sum_ff, sum_in;
   logic signed [16:0] prev_ff, prev_in;
   logic               have_prev_ff, have_prev_in;
   err_type            err_ff, err_in;

   logic signed [16:0] e;
   logic signed [16:0] prev_use;
   logic signed [32:0] sum_wide;
   logic signed [31:0] sum_sat;
   logic               flip;
   logic               off;
   logic signed [16:0] hd_diff, hd_rem, hd_wrap;

   always_comb begin
      // speed error and saturating integral
      off      = (sample.target_speed == 16'sd0);
      e        = 17'(sample.target_speed) - 17'(sample.ground_speed);
      prev_use = have_prev_ff ? prev_ff : e;
      sum_wide = 33'(sum_ff) + 33'(e);
      if (sum_wide[32] != sum_wide[31]) begin
         sum_sat = sum_wide[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
      end else begin
         sum_sat = sum_wide[31:0];
      end
      // sign change clears the integral
      flip = ((prev_use < 0) && (e > 0)) || ((prev_use > 0) && (e < 0));

      sum_in       = sum_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      if (commit && !off) begin
         sum_in       = flip ? 32'sd0 : sum_sat;
         prev_in      = e;
         have_prev_in = 1'b1;
      end

      // heading error, remainder by a turn then wrap to half a turn
      hd_diff = $signed({1'b0, sample.target_heading}) - $signed({1'b0, sample.heading_now});
      if (hd_diff >= $signed(17'(TURN))) begin
         hd_rem = hd_diff - $signed(17'(TURN));
      end else if (hd_diff <= -$signed(17'(TURN))) begin
         hd_rem = hd_diff + $signed(17'(TURN));
      end else begin
         hd_rem = hd_diff;
      end
      if (hd_rem > $signed(17'(HALF_TURN))) begin
         hd_wrap = hd_rem - $signed(17'(TURN));
      end else if (hd_rem < -$signed(17'(HALF_TURN))) begin
         hd_wrap = hd_rem + $signed(17'(TURN));
      end else begin
         hd_wrap = hd_rem;
      end

      err_in.speed_off    = off;
      err_in.speed_err    = e;
      err_in.err_sum      = flip ? 32'sd0 : sum_sat;
      err_in.heading_err  = hd_wrap;
      err_in.altitude_err = 19'(sample.altitude_now) - 19'(sample.target_altitude);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         err_ff <= err_in;
      end
   end

   assign err = err_ff;

endmodule

>>> design/asp_mul_stage.sv
// product stage: gain multiplications, one register after them
`timescale 1ns / 1ps

module asp_mul_stage (
   input  logic             clock,
   input  logic             load,
   input  asp_pkg::err_type err,
   input  logic [15:0]      speed_gain_p,
   input  logic [15:0]      speed_gain_i,
   input  logic [15:0]      heading_gain,
   input  logic [15:0]      altitude_gain,
   output asp_pkg::prod_type prod
);
   import asp_pkg::*;

   prod_type           prod_ff, prod_in;
   logic signed [16:0] kp, ki, kh, ka;

   always_comb begin
      kp = $signed({1'b0, speed_gain_p});
      ki = $signed({1'b0, speed_gain_i});
      kh = $signed({1'b0, heading_gain});
      ka = $signed({1'b0, altitude_gain});
      prod_in.speed_off  = err.speed_off;
      prod_in.p_term     = 34'(err.speed_err) * 34'(kp);
      prod_in.i_term     = 49'(err.err_sum) * 49'(ki);
      prod_in.roll_prod  = 34'(err.heading_err) * 34'(kh);
      prod_in.pitch_prod = 36'(err.altitude_err) * 36'(ka);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

>>> design/asp_out_stage.sv
// result stage: power sum and scaling, roll and pitch scaling and limits
`timescale 1ns / 1ps

module asp_out_stage (
   input  logic              clock,
   input  logic              load,
   input  asp_pkg::prod_type prod,
   input  logic [14:0]       roll_limit,
   input  logic [13:0]       pitch_limit,
   output logic [14:0]       power_cmd,
   output logic signed [15:0] roll_cmd,
   output logic signed [14:0] pitch_cmd
);
   import asp_pkg::*;

   logic        [14:0] power_ff, power_in;
   logic signed [15:0] roll_ff, roll_in;
   logic signed [14:0] pitch_ff, pitch_in;

   logic signed [49:0] raw;
   logic signed [41:0] raw_q;
   logic signed [25:0] roll_t, roll_lim;
   logic signed [27:0] pitch_t, pitch_lim;
   logic        [14:0] roll_cap;
   logic        [13:0] pitch_cap;

   always_comb begin
      // power: floor of the scaled sum, clamped to full power
      raw   = 50'(prod.p_term) + 50'(prod.i_term);
      raw_q = 42'(raw >>> 8);
      if (prod.speed_off || (raw <= 0)) begin
         power_in = '0;
      end else if (raw_q > $signed(42'(POWER_FULL))) begin
         power_in = 15'(POWER_FULL);
      end else begin
         power_in = raw_q[14:0];
      end

      // roll: scale toward zero, clamp to the capped limit
      roll_cap = (roll_limit > 15'(ROLL_CAP)) ? 15'(ROLL_CAP) : roll_limit;
      roll_lim = $signed({11'd0, roll_cap});
      if (prod.roll_prod < 0) begin
         roll_t = 26'((prod.roll_prod + 34'sd255) >>> 8);
      end else begin
         roll_t = 26'(prod.roll_prod >>> 8);
      end
      if (roll_t > roll_lim) begin
         roll_in = 16'(roll_lim);
      end else if (roll_t < -roll_lim) begin
         roll_in = 16'(-roll_lim);
      end else begin
         roll_in = 16'(roll_t);
      end

      // pitch: same scaling on the altitude product
      pitch_cap = (pitch_limit > 14'(PITCH_CAP)) ? 14'(PITCH_CAP) : pitch_limit;
      pitch_lim = $signed({14'd0, pitch_cap});
      if (prod.pitch_prod < 0) begin
         pitch_t = 28'((prod.pitch_prod + 36'sd255) >>> 8);
      end else begin
         pitch_t = 28'(prod.pitch_prod >>> 8);
      end
      if (pitch_t > pitch_lim) begin
         pitch_in = 15'(pitch_lim);
      end else if (pitch_t < -pitch_lim) begin
         pitch_in = 15'(-pitch_lim);
      end else begin
         pitch_in = 15'(pitch_t);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         power_ff <= power_in;
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
      end
   end

   assign power_cmd = power_ff;
   assign roll_cmd  = roll_ff;
   assign pitch_cmd = pitch_ff;

endmodule

>>> design/attitude_speed_pid_controller_top.sv
// top level of the attitude and speed controller
`timescale 1ns / 1ps
`include "assert_macros.svh"

// attitude and speed controller
// - req_ channel: one navigation sample per beat (speeds, headings, altitudes)
// - rsp_ channel: one control beat per sample (power, roll, pitch), in order
// - csr_ channel: register writes, index as in asp_pkg::csr_index_type,
//   always ready; write only while no sample is in flight
// - four register stages: input register, error stage (holds the speed
//   integral), multiplier stage, result register
// - a sample passes the input register, error stage, multiplier stage and
//   result register in that order before its result is offered on rsp_
// - throughput: one sample per cycle while rsp_stall is low; the integral
//   update sits in the error stage, so no sample waits on the one before
// - a stalled rsp_ beat holds; the stages behind it keep filling bubbles and
//   req_stall rises only when all four stages hold samples
// - reset (synchronous, active high) empties the stages, clears the
//   integral and previous error, and loads the register defaults
module attitude_speed_pid_controller_top (
   input  logic               clock,
   input  logic               reset,
   // sample channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_ground_speed,
   input  logic signed [15:0] req_target_speed,
   input  logic        [15:0] req_heading_now,
   input  logic        [15:0] req_target_heading,
   input  logic signed [17:0] req_altitude_now,
   input  logic signed [17:0] req_target_altitude,
   // control channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [14:0] rsp_power_cmd,
   output logic signed [15:0] rsp_roll_cmd,
   output logic signed [14:0] rsp_pitch_cmd,
   // register write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [2:0]  csr_index,
   input  logic        [15:0] csr_data
);
   import asp_pkg::*;

   // configuration registers
   logic [15:0] speed_gain_p_ff, speed_gain_i_ff, heading_gain_ff, altitude_gain_ff;
   logic [14:0] roll_limit_ff;
   logic [13:0] pitch_limit_ff;

   // stage valids and enables
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s0_en, s1_en, s2_en, s3_en;

   sample_type sample_ff, sample_in;
   err_type    err;
   prod_type   prod;

   // a stage loads when it is empty or the one ahead of it moves
   assign s3_en = !s3_valid_ff || !rsp_stall;
   assign s2_en = !s2_valid_ff || s3_en;
   assign s1_en = !s1_valid_ff || s2_en;
   assign s0_en = !s0_valid_ff || s1_en;

   assign req_stall = !s0_en;
   assign rsp_valid = s3_valid_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      sample_in.ground_speed    = req_ground_speed;
      sample_in.target_speed    = req_target_speed;
      sample_in.heading_now     = req_heading_now;
      sample_in.target_heading  = req_target_heading;
      sample_in.altitude_now    = req_altitude_now;
      sample_in.target_altitude = req_target_altitude;
   end

   // input register
   always_ff @(posedge clock) begin
      if (s0_en) begin
         sample_ff <= sample_in;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s0_en) s0_valid_ff <= req_valid;
         if (s1_en) s1_valid_ff <= s0_valid_ff;
         if (s2_en) s2_valid_ff <= s1_valid_ff;
         if (s3_en) s3_valid_ff <= s2_valid_ff;
      end
   end

   // register writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_gain_p_ff  <= SPEED_GAIN_P_RESET;
         speed_gain_i_ff  <= SPEED_GAIN_I_RESET;
         heading_gain_ff  <= HEADING_GAIN_RESET;
         altitude_gain_ff <= ALTITUDE_GAIN_RESET;
         roll_limit_ff    <= ROLL_LIMIT_RESET;
         pitch_limit_ff   <= PITCH_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SPEED_GAIN_P:  speed_gain_p_ff  <= csr_data;
            CSR_SPEED_GAIN_I:  speed_gain_i_ff  <= csr_data;
            CSR_HEADING_GAIN:  heading_gain_ff  <= csr_data;
            CSR_ALTITUDE_GAIN: altitude_gain_ff <= csr_data;
            CSR_ROLL_LIMIT:    roll_limit_ff    <= csr_data[14:0];
            CSR_PITCH_LIMIT:   pitch_limit_ff   <= csr_data[13:0];
            default: ;
         endcase
      end
   end

   // error stage; the integral moves only when a real sample enters it
   asp_err_stage u_err (
      .clock  (clock),
      .reset  (reset),
      .load   (s1_en),
      .commit (s1_en && s0_valid_ff),
      .sample (sample_ff),
      .err    (err)
   );

   // gain products
   asp_mul_stage u_mul (
      .clock         (clock),
      .load          (s2_en),
      .err           (err),
      .speed_gain_p  (speed_gain_p_ff),
      .speed_gain_i  (speed_gain_i_ff),
      .heading_gain  (heading_gain_ff),
      .altitude_gain (altitude_gain_ff),
      .prod          (prod)
   );

   // result register
   asp_out_stage u_out (
      .clock       (clock),
      .load        (s3_en),
      .prod        (prod),
      .roll_limit  (roll_limit_ff),
      .pitch_limit (pitch_limit_ff),
      .power_cmd   (rsp_power_cmd),
      .roll_cmd    (rsp_roll_cmd),
      .pitch_cmd   (rsp_pitch_cmd)
   );

   // sample side stalls only with every stage occupied
   `ASP_ASSERT(a_stall_full, clock, reset,
      req_stall |-> (s0_valid_ff && s1_valid_ff && s2_valid_ff && s3_valid_ff))
   // roll never leaves half a turn
   `ASP_ASSERT(a_roll_range, clock, reset,
      rsp_valid |-> ((rsp_roll_cmd <= 16'sd18000) && (rsp_roll_cmd >= -16'sd18000)))
   // pitch never leaves the pitch cap
   `ASP_ASSERT(a_pitch_range, clock, reset,
      rsp_valid |-> ((rsp_pitch_cmd <= 15'sd9000) && (rsp_pitch_cmd >= -15'sd9000)))
   // a beat that leaves while the product stage is empty leaves no valid beat behind it
   `ASP_ASSERT(a_refill, clock, reset,
      (rsp_valid && !rsp_stall && !s2_valid_ff) |=> !rsp_valid)

endmodule
